// ===== sv/mxeu_pkg.sv =====
// Package: shared types and opcode constants for the integer execute unit.
package mxeu_pkg;

    localparam int XLEN = 64;
    localparam int NREG = 32;
    localparam int RIDX = 5;

    localparam logic [1:0] ST_EXEC   = 2'd0;
    localparam logic [1:0] ST_ANNUL  = 2'd1;
    localparam logic [1:0] ST_UNSUPP = 2'd2;

    localparam logic [5:0] OP_FUNCT_GRP = 6'h00;
    localparam logic [5:0] OP_RT_GRP    = 6'h01;
    localparam logic [5:0] OP_J         = 6'h02;
    localparam logic [5:0] OP_JAL       = 6'h03;
    localparam logic [5:0] OP_BEQ       = 6'h04;
    localparam logic [5:0] OP_BNE       = 6'h05;
    localparam logic [5:0] OP_BGTZ      = 6'h07;
    localparam logic [5:0] OP_ADD_IMM   = 6'h09;
    localparam logic [5:0] OP_SLTI      = 6'h0a;
    localparam logic [5:0] OP_SLT_IMM_U = 6'h0b;
    localparam logic [5:0] OP_ANDI      = 6'h0c;
    localparam logic [5:0] OP_ORI       = 6'h0d;
    localparam logic [5:0] OP_XORI      = 6'h0e;
    localparam logic [5:0] OP_LUI       = 6'h0f;
    localparam logic [5:0] OP_BEQL      = 6'h14;
    localparam logic [5:0] OP_BGTZ_LKLY = 6'h17;
    localparam logic [5:0] OP_DADD_IMM  = 6'h19;

    localparam logic [5:0] FN_SLL    = 6'h00;
    localparam logic [5:0] FN_SRL    = 6'h02;
    localparam logic [5:0] FN_SRA    = 6'h03;
    localparam logic [5:0] FN_SLLV   = 6'h04;
    localparam logic [5:0] FN_SRLV   = 6'h06;
    localparam logic [5:0] FN_SRAV   = 6'h07;
    localparam logic [5:0] FN_JR     = 6'h08;
    localparam logic [5:0] FN_JALR   = 6'h09;
    localparam logic [5:0] FN_MFHI   = 6'h10;
    localparam logic [5:0] FN_MTHI   = 6'h11;
    localparam logic [5:0] FN_MFLO   = 6'h12;
    localparam logic [5:0] FN_MTLO   = 6'h13;
    localparam logic [5:0] FN_DSLLV  = 6'h14;
    localparam logic [5:0] FN_DSRLV  = 6'h16;
    localparam logic [5:0] FN_DSRAV  = 6'h17;
    localparam logic [5:0] FN_ADDU   = 6'h21;
    localparam logic [5:0] FN_SUBU   = 6'h23;
    localparam logic [5:0] FN_AND    = 6'h24;
    localparam logic [5:0] FN_OR     = 6'h25;
    localparam logic [5:0] FN_XOR    = 6'h26;
    localparam logic [5:0] FN_NOR    = 6'h27;
    localparam logic [5:0] FN_SLT    = 6'h2a;
    localparam logic [5:0] FN_SLTU   = 6'h2b;
    localparam logic [5:0] FN_DADDU  = 6'h2d;
    localparam logic [5:0] FN_DSUBU  = 6'h2f;
    localparam logic [5:0] FN_DSLL   = 6'h38;
    localparam logic [5:0] FN_DSRL   = 6'h3a;
    localparam logic [5:0] FN_DSRA   = 6'h3b;
    localparam logic [5:0] FN_DSLL32 = 6'h3c;
    localparam logic [5:0] FN_DSRL32 = 6'h3e;
    localparam logic [5:0] FN_DSRA32 = 6'h3f;

    localparam logic [4:0] RT_BLTZ          = 5'h00;
    localparam logic [4:0] RT_BGEZ          = 5'h01;
    localparam logic [4:0] RT_BLTZ_LKLY     = 5'h02;
    localparam logic [4:0] RT_BGEZ_LKLY     = 5'h03;
    localparam logic [4:0] RT_BLTZ_LNK      = 5'h10;
    localparam logic [4:0] RT_BGEZ_LNK      = 5'h11;
    localparam logic [4:0] RT_BLTZ_LNK_LKLY = 5'h12;
    localparam logic [4:0] RT_BGEZ_LNK_LKLY = 5'h13;

    localparam logic [4:0] LINK_REG = 5'd31;

    typedef struct packed {
        logic [31:0] instruction;
        logic [31:0] fetch_address;
    } t_in;

    typedef struct packed {
        logic [31:0] next_address;
        logic [1:0]  status;
        logic [4:0]  dest_register;
        logic [63:0] dest_value;
    } t_out;

    // Architectural writes decided for one instruction.
    typedef struct packed {
        logic        rf_we;
        logic [4:0]  rf_addr;
        logic [63:0] rf_data;
        logic        hi_we;
        logic        lo_we;
        logic [63:0] hilo_data;
        logic        ds_we;
        logic        ds_val;
        logic [31:0] after_addr;
        logic        annul_val;
    } t_upd;

    function automatic logic [63:0] sx32(input logic [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

endpackage

// ===== sv/mxeu_regfile.sv =====
// Register file: 32 x 64-bit flops with two combinational read ports, entry 0 reads zero.
module mxeu_regfile import mxeu_pkg::*; #(
    parameter int WIDTH = XLEN
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [RIDX-1:0]  i_ra,
    input  logic [RIDX-1:0]  i_rb,
    output logic [WIDTH-1:0] o_da,
    output logic [WIDTH-1:0] o_db,
    input  logic             i_we,
    input  logic [RIDX-1:0]  i_wa,
    input  logic [WIDTH-1:0] i_wd
);
    logic [WIDTH-1:0] r_regs [NREG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NREG; k++) r_regs[k] <= '0;
        end else if (i_we && i_wa != '0) begin
            r_regs[i_wa] <= i_wd;
        end
    end

    assign o_da = (i_ra == '0) ? '0 : r_regs[i_ra];
    assign o_db = (i_rb == '0) ? '0 : r_regs[i_rb];
endmodule

// ===== sv/mxeu_exec.sv =====
// Execute logic: decode, ALU, branch resolution and delay-slot control for one instruction.
module mxeu_exec import mxeu_pkg::*; (
    input  logic [31:0] i_ins,
    input  logic [31:0] i_pc,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    input  logic [63:0] i_hi,
    input  logic [63:0] i_lo,
    input  logic        i_in_slot,
    input  logic        i_annul,
    input  logic [31:0] i_after,
    output t_out        o_res,
    output t_upd        o_upd
);
    logic [5:0]  op, fn;
    logic [4:0]  rt, rd, sa;
    logic [15:0] imm;
    logic [63:0] simm;
    logic        is_br;
    logic        alu_ok, br_ok;
    logic [4:0]  alu_tgt;
    logic [63:0] val;
    logic        wr_hi, wr_lo;
    logic [31:0] al, bl, link, btgt, target;
    logic        taken, likely, neg;
    logic [4:0]  lreg;

    assign op   = i_ins[31:26];
    assign fn   = i_ins[5:0];
    assign rt   = i_ins[20:16];
    assign rd   = i_ins[15:11];
    assign sa   = i_ins[10:6];
    assign imm  = i_ins[15:0];
    assign simm = {{48{imm[15]}}, imm};
    assign al   = i_a[31:0];
    assign bl   = i_b[31:0];
    assign link = i_pc + 32'd8;
    assign btgt = i_pc + 32'd4 + {simm[29:0], 2'b00};
    assign neg  = i_a[63];

    assign is_br = (op == OP_J) || (op == OP_JAL) || (op == OP_RT_GRP)
                || (op >= OP_BEQ && op <= OP_BGTZ) || (op >= OP_BEQL && op <= OP_BGTZ_LKLY)
                || (op == OP_FUNCT_GRP && (fn == FN_JR || fn == FN_JALR));

    always_comb begin
        alu_ok  = 1'b1;
        alu_tgt = rt;
        val     = '0;
        wr_hi   = 1'b0;
        wr_lo   = 1'b0;
        if (op == OP_FUNCT_GRP) begin
            alu_tgt = rd;
            case (fn)
                FN_SLL:    val = sx32(bl << sa);
                FN_SRL:    val = sx32(bl >> sa);
                FN_SRA:    val = sx32(32'($signed(bl) >>> sa));
                FN_SLLV:   val = sx32(bl << al[4:0]);
                FN_SRLV:   val = sx32(bl >> al[4:0]);
                FN_SRAV:   val = sx32(32'($signed(bl) >>> al[4:0]));
                FN_MFHI:   val = i_hi;
                FN_MTHI:   begin wr_hi = 1'b1; alu_tgt = '0; end
                FN_MFLO:   val = i_lo;
                FN_MTLO:   begin wr_lo = 1'b1; alu_tgt = '0; end
                FN_DSLLV:  val = i_b << al[5:0];
                FN_DSRLV:  val = i_b >> al[5:0];
                FN_DSRAV:  val = 64'($signed(i_b) >>> al[5:0]);
                FN_ADDU:   val = sx32(al + bl);
                FN_SUBU:   val = sx32(al - bl);
                FN_AND:    val = i_a & i_b;
                FN_OR:     val = i_a | i_b;
                FN_XOR:    val = i_a ^ i_b;
                FN_NOR:    val = ~(i_a | i_b);
                FN_SLT:    val = {63'd0, $signed(i_a) < $signed(i_b)};
                FN_SLTU:   val = {63'd0, i_a < i_b};
                FN_DADDU:  val = i_a + i_b;
                FN_DSUBU:  val = i_a - i_b;
                FN_DSLL:   val = i_b << sa;
                FN_DSRL:   val = i_b >> sa;
                FN_DSRA:   val = 64'($signed(i_b) >>> sa);
                FN_DSLL32: val = i_b << {1'b1, sa};
                FN_DSRL32: val = i_b >> {1'b1, sa};
                FN_DSRA32: val = 64'($signed(i_b) >>> {1'b1, sa});
                default:   alu_ok = 1'b0;
            endcase
        end else begin
            case (op)
                OP_ADD_IMM:   val = sx32(al + simm[31:0]);
                OP_SLTI:      val = {63'd0, $signed(i_a) < $signed(simm)};
                OP_SLT_IMM_U: val = {63'd0, i_a < simm};
                OP_ANDI:      val = i_a & {48'd0, imm};
                OP_ORI:       val = i_a | {48'd0, imm};
                OP_XORI:      val = i_a ^ {48'd0, imm};
                OP_LUI:       val = sx32({imm, 16'd0});
                OP_DADD_IMM:  val = i_a + simm;
                default:      alu_ok = 1'b0;
            endcase
        end
    end

    always_comb begin
        br_ok  = 1'b1;
        taken  = 1'b1;
        likely = 1'b0;
        lreg   = '0;
        target = btgt;
        if (op == OP_J || op == OP_JAL) begin
            target = {(i_pc[31:28] + {3'd0, i_pc[27:2] == 26'h3ffffff}), i_ins[25:0], 2'b00};
            if (op == OP_JAL) lreg = LINK_REG;
        end else if (op == OP_FUNCT_GRP) begin
            target = al;
            if (fn == FN_JALR) lreg = rd;
        end else if (op == OP_RT_GRP) begin
            case (rt)
                RT_BLTZ:          taken = neg;
                RT_BGEZ:          taken = !neg;
                RT_BLTZ_LKLY:     begin taken = neg;  likely = 1'b1; end
                RT_BGEZ_LKLY:     begin taken = !neg; likely = 1'b1; end
                RT_BLTZ_LNK:      begin taken = neg;  lreg = LINK_REG; end
                RT_BGEZ_LNK:      begin taken = !neg; lreg = LINK_REG; end
                RT_BLTZ_LNK_LKLY: begin taken = neg;  lreg = LINK_REG; likely = 1'b1; end
                RT_BGEZ_LNK_LKLY: begin taken = !neg; lreg = LINK_REG; likely = 1'b1; end
                default:          br_ok = 1'b0;
            endcase
        end else begin
            likely = op >= OP_BEQL;
            case (op[1:0])
                2'd0:    taken = i_a == i_b;
                2'd1:    taken = i_a != i_b;
                2'd2:    taken = (i_a == '0) || neg;
                default: taken = (i_a != '0) && !neg;
            endcase
        end
    end

    always_comb begin
        o_res = '{next_address: i_pc, status: ST_UNSUPP, dest_register: '0, dest_value: '0};
        o_upd = '0;
        o_upd.hilo_data = i_a;
        if (i_annul) begin
            o_res.status       = ST_ANNUL;
            o_res.next_address = i_after;
            o_upd.ds_we        = 1'b1;
        end else if (!is_br && alu_ok) begin
            o_res.status       = ST_EXEC;
            o_res.next_address = i_in_slot ? i_after : i_pc + 32'd4;
            o_upd.ds_we        = i_in_slot;
            o_upd.hi_we        = wr_hi;
            o_upd.lo_we        = wr_lo;
            if (alu_tgt != '0) begin
                o_res.dest_register = alu_tgt;
                o_res.dest_value    = val;
            end
        end else if (is_br && !i_in_slot && br_ok) begin
            o_res.status       = ST_EXEC;
            o_res.next_address = i_pc + 32'd4;
            o_upd.ds_we        = 1'b1;
            o_upd.ds_val       = 1'b1;
            o_upd.after_addr   = taken ? target : link;
            o_upd.annul_val    = likely && !taken;
            if (lreg != '0) begin
                o_res.dest_register = lreg;
                o_res.dest_value    = sx32(link);
            end
        end
        o_upd.rf_we   = o_res.dest_register != '0;
        o_upd.rf_addr = o_res.dest_register;
        o_upd.rf_data = o_res.dest_value;
    end
endmodule

// ===== sv/mips3_integer_execute_unit.sv =====
// Top level: MIPS III integer execute unit with input and result registers.
// One instruction is taken per cycle unless the result is held off; it passes through the
// input register and then the result register before its result is offered. The sustained
// rate without hold-off is one instruction per cycle, set by the single pass from the input
// register through the register-file read, ALU and write-back to the result register. The
// input stalls only while both registers are full and the result is held off. The register
// file, HI, LO and delay-slot state live in flops and are cleared by reset; no clearing
// pass is needed.
module mips3_integer_execute_unit import mxeu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);
    logic        r_in_v, r_out_v;
    t_in         r_in;
    t_out        r_out;
    logic [XLEN-1:0] r_hi, r_lo;
    logic        r_slot, r_annul;
    logic [31:0] r_after;
    logic [XLEN-1:0] da, db;
    t_out        res;
    t_upd        upd;
    logic        adv;

    assign adv     = r_in_v && (!r_out_v || !i_stall);
    assign o_stall = r_in_v && !adv;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    mxeu_regfile #(.WIDTH(XLEN)) u_rf (
        .i_clk, .i_rst_n,
        .i_ra(r_in.instruction[25:21]), .i_rb(r_in.instruction[20:16]),
        .o_da(da), .o_db(db),
        .i_we(adv && upd.rf_we), .i_wa(upd.rf_addr), .i_wd(upd.rf_data)
    );

    mxeu_exec u_ex (
        .i_ins(r_in.instruction), .i_pc(r_in.fetch_address),
        .i_a(da), .i_b(db), .i_hi(r_hi), .i_lo(r_lo),
        .i_in_slot(r_slot), .i_annul(r_annul), .i_after(r_after),
        .o_res(res), .o_upd(upd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_hi    <= '0;
            r_lo    <= '0;
            r_slot  <= 1'b0;
            r_annul <= 1'b0;
            r_after <= '0;
        end else begin
            if (!o_stall) begin
                r_in_v <= i_valid;
                if (i_valid) r_in <= i_data;
            end
            if (adv) begin
                r_out_v <= 1'b1;
                r_out   <= res;
                if (upd.hi_we) r_hi <= upd.hilo_data;
                if (upd.lo_we) r_lo <= upd.hilo_data;
                if (upd.ds_we) begin
                    r_slot  <= upd.ds_val;
                    r_annul <= upd.annul_val;
                    if (upd.ds_val) r_after <= upd.after_addr;
                end
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end
endmodule

// ===== sv/mxeu_checker.sv =====
// Checker: port-level assertions for the execute unit, bound to the top level.
module mxeu_checker import mxeu_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.status <= ST_UNSUPP)
        else $error("bad status code");
    a_nodest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != ST_EXEC |-> o_data.dest_register == '0)
        else $error("register written by non-executed item");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.dest_register == '0 |-> o_data.dest_value == '0)
        else $error("value without destination");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> ##1 o_valid)
        else $error("transfer produced no result");
endmodule

bind mips3_integer_execute_unit mxeu_checker u_chk (.*);

// ===== dv/tb.sv =====
// Testbench: drives random and directed MIPS III instructions through the execute unit
`timescale 1ns / 100ps

module tb;
    import mxeu_pkg::*;

    localparam logic [5:0] OP_UNUSED = 6'h3f;
    localparam logic [5:0] FN_UNUSED = 6'h3d;

    class exec_scoreboard;
        logic [63:0] regs [32];
        logic [63:0] hi_q, lo_q;
        bit          slot_q, annul_q;
        logic [31:0] after_q;
        t_out        pending [$];
        int          errors, checked;

        function void clear();
            foreach (regs[i]) regs[i] = '0;
            hi_q = '0; lo_q = '0; slot_q = 0; annul_q = 0; after_q = '0;
            errors = 0; checked = 0;
        endfunction

        function bit is_jump(logic [31:0] ins);
            logic [5:0] op;
            op = ins[31:26];
            if (op == OP_J || op == OP_JAL || op == OP_RT_GRP) return 1;
            if (op >= OP_BEQ && op <= OP_BGTZ) return 1;
            if (op >= OP_BEQL && op <= OP_BGTZ_LKLY) return 1;
            return op == OP_FUNCT_GRP && (ins[5:0] == FN_JR || ins[5:0] == FN_JALR);
        endfunction

        function bit alu(logic [31:0] ins, output logic [4:0] d, output logic [63:0] v);
            logic [63:0] a, b, val, imx;
            logic [31:0] al, bl, t32;
            logic [4:0]  sa, tgt;
            a = regs[ins[25:21]]; b = regs[ins[20:16]];
            al = a[31:0]; bl = b[31:0]; sa = ins[10:6]; tgt = ins[20:16];
            imx = {{48{ins[15]}}, ins[15:0]};
            d = '0; v = '0; val = '0;
            if (ins[31:26] == OP_FUNCT_GRP) begin
                tgt = ins[15:11];
                case (ins[5:0])
                    FN_SLL:    begin t32 = bl << sa; val = {{32{t32[31]}}, t32}; end
                    FN_SRL:    begin t32 = bl >> sa; val = {{32{t32[31]}}, t32}; end
                    FN_SRA:    begin t32 = $signed(bl) >>> sa; val = {{32{t32[31]}}, t32}; end
                    FN_SLLV:   begin t32 = bl << al[4:0]; val = {{32{t32[31]}}, t32}; end
                    FN_SRLV:   begin t32 = bl >> al[4:0]; val = {{32{t32[31]}}, t32}; end
                    FN_SRAV:   begin
                        t32 = $signed(bl) >>> al[4:0]; val = {{32{t32[31]}}, t32};
                    end
                    FN_MFHI:   val = hi_q;
                    FN_MTHI:   begin hi_q = a; return 1; end
                    FN_MFLO:   val = lo_q;
                    FN_MTLO:   begin lo_q = a; return 1; end
                    FN_DSLLV:  val = b << al[5:0];
                    FN_DSRLV:  val = b >> al[5:0];
                    FN_DSRAV:  val = $signed(b) >>> al[5:0];
                    FN_ADDU:   begin t32 = al + bl; val = {{32{t32[31]}}, t32}; end
                    FN_SUBU:   begin t32 = al - bl; val = {{32{t32[31]}}, t32}; end
                    FN_AND:    val = a & b;
                    FN_OR:     val = a | b;
                    FN_XOR:    val = a ^ b;
                    FN_NOR:    val = ~(a | b);
                    FN_SLT:    val = {63'd0, $signed(a) < $signed(b)};
                    FN_SLTU:   val = {63'd0, a < b};
                    FN_DADDU:  val = a + b;
                    FN_DSUBU:  val = a - b;
                    FN_DSLL:   val = b << sa;
                    FN_DSRL:   val = b >> sa;
                    FN_DSRA:   val = $signed(b) >>> sa;
                    FN_DSLL32: val = b << (sa + 32);
                    FN_DSRL32: val = b >> (sa + 32);
                    FN_DSRA32: val = $signed(b) >>> (sa + 32);
                    default:   return 0;
                endcase
            end else begin
                case (ins[31:26])
                    OP_ADD_IMM:   begin t32 = al + imx[31:0]; val = {{32{t32[31]}}, t32}; end
                    OP_SLTI:      val = {63'd0, $signed(a) < $signed(imx)};
                    OP_SLT_IMM_U: val = {63'd0, a < imx};
                    OP_ANDI:      val = a & {48'd0, ins[15:0]};
                    OP_ORI:       val = a | {48'd0, ins[15:0]};
                    OP_XORI:      val = a ^ {48'd0, ins[15:0]};
                    OP_LUI:       val = {{32{ins[15]}}, ins[15:0], 16'd0};
                    OP_DADD_IMM:  val = a + imx;
                    default:      return 0;
                endcase
            end
            if (tgt != 0) begin d = tgt; v = val; end
            return 1;
        endfunction

        function bit jump(logic [31:0] ins, logic [31:0] pc, output logic [4:0] d,
                          output logic [63:0] v);
            logic [63:0] a, b;
            logic [31:0] lnk, seq, target;
            logic [4:0]  lreg;
            bit          taken, likely, neg;
            a = regs[ins[25:21]]; b = regs[ins[20:16]];
            lnk = pc + 32'd8; seq = pc + 32'd4;
            target = seq + {{14{ins[15]}}, ins[15:0], 2'b00};
            lreg = '0; taken = 1; likely = 0; neg = a[63];
            d = '0; v = '0;
            if (ins[31:26] == OP_J || ins[31:26] == OP_JAL) begin
                target = {seq[31:28], ins[25:0], 2'b00};
                if (ins[31:26] == OP_JAL) lreg = LINK_REG;
            end else if (ins[31:26] == OP_FUNCT_GRP) begin
                target = a[31:0];
                if (ins[5:0] == FN_JALR) lreg = ins[15:11];
            end else if (ins[31:26] == OP_RT_GRP) begin
                case (ins[20:16])
                    RT_BLTZ:          taken = neg;
                    RT_BGEZ:          taken = !neg;
                    RT_BLTZ_LKLY:     begin taken = neg; likely = 1; end
                    RT_BGEZ_LKLY:     begin taken = !neg; likely = 1; end
                    RT_BLTZ_LNK:      begin taken = neg; lreg = LINK_REG; end
                    RT_BGEZ_LNK:      begin taken = !neg; lreg = LINK_REG; end
                    RT_BLTZ_LNK_LKLY: begin taken = neg; lreg = LINK_REG; likely = 1; end
                    RT_BGEZ_LNK_LKLY: begin taken = !neg; lreg = LINK_REG; likely = 1; end
                    default:          return 0;
                endcase
            end else begin
                likely = ins[31:26] >= OP_BEQL;
                case (ins[27:26])
                    2'd0: taken = a == b;
                    2'd1: taken = a != b;
                    2'd2: taken = a == 0 || neg;
                    default: taken = a != 0 && !neg;
                endcase
            end
            if (lreg != 0) begin d = lreg; v = {{32{lnk[31]}}, lnk}; end
            slot_q = 1; after_q = taken ? target : lnk; annul_q = likely && !taken;
            return 1;
        endfunction

        function void note_input(t_in it);
            t_out r;
            logic [4:0]  d;
            logic [63:0] v;
            r = '0; d = '0; v = '0;
            r.status = ST_EXEC;
            if (annul_q) begin
                r.status = ST_ANNUL; r.next_address = after_q; annul_q = 0; slot_q = 0;
            end else if (slot_q) begin
                if (is_jump(it.instruction) || !alu(it.instruction, d, v)) begin
                    r.status = ST_UNSUPP; r.next_address = it.fetch_address; d = '0; v = '0;
                end else begin
                    r.next_address = after_q; slot_q = 0;
                end
            end else if (is_jump(it.instruction)) begin
                if (jump(it.instruction, it.fetch_address, d, v))
                    r.next_address = it.fetch_address + 32'd4;
                else begin
                    r.status = ST_UNSUPP; r.next_address = it.fetch_address;
                end
            end else if (alu(it.instruction, d, v)) begin
                r.next_address = it.fetch_address + 32'd4;
            end else begin
                r.status = ST_UNSUPP; r.next_address = it.fetch_address;
            end
            if (d != 0) regs[d] = v;
            r.dest_register = d; r.dest_value = v;
            pending.push_back(r);
        endfunction

        function void check_result(t_out got);
            t_out e;
            checked++;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", '0, '0);
                return;
            end
            e = pending.pop_front();
            if (got.next_address !== e.next_address)
                report_mismatch("next_address", 64'(got.next_address), 64'(e.next_address));
            if (got.status !== e.status)
                report_mismatch("status", 64'(got.status), 64'(e.status));
            if (got.dest_register !== e.dest_register)
                report_mismatch("dest_register", 64'(got.dest_register),
                                64'(e.dest_register));
            if (got.dest_value !== e.dest_value)
                report_mismatch("dest_value", got.dest_value, e.dest_value);
        endfunction

        function void report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("mismatch %0s: got %h want %h (result %0d)", what, got, want, checked);
        endfunction
    endclass

    logic i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall;
    t_in  i_data;
    t_out o_data;

    exec_scoreboard sb;
    int send_idle_pct, recv_idle_pct, hold_cycles, quiet_cycles, sent;
    bit timed_out, hold_armed, hold_done;

    mips3_integer_execute_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [31:0] random_word();
        logic [31:0] ins;
        logic [5:0]  fns [29];
        logic [5:0]  ops [13];
        logic [4:0]  rts [8];
        fns = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_MFHI, FN_MTHI,
                FN_MFLO, FN_MTLO, FN_DSLLV, FN_DSRLV, FN_DSRAV, FN_ADDU, FN_SUBU, FN_AND,
                FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU, FN_DADDU, FN_DSUBU, FN_DSLL,
                FN_DSRL, FN_DSRA, FN_DSLL32, FN_DSRL32, FN_DSRA32};
        ops = '{OP_ADD_IMM, OP_SLTI, OP_SLT_IMM_U, OP_ANDI, OP_ORI, OP_XORI, OP_LUI,
                OP_DADD_IMM, OP_J, OP_JAL, OP_BEQ, OP_BEQL, OP_RT_GRP};
        rts = '{RT_BLTZ, RT_BGEZ, RT_BLTZ_LKLY, RT_BGEZ_LKLY, RT_BLTZ_LNK, RT_BGEZ_LNK,
                RT_BLTZ_LNK_LKLY, RT_BGEZ_LNK_LKLY};
        ins = $urandom;
        // keep register numbers small so values chain together
        if ($urandom_range(0, 1)) begin
            ins[25:21] = 5'($urandom_range(0, 7)); ins[20:16] = 5'($urandom_range(0, 7));
            ins[15:11] = 5'($urandom_range(0, 7));
        end
        case ($urandom_range(0, 19))
            0: ; // raw noise
            1, 2, 3, 4, 5, 6, 7: begin
                ins[31:26] = OP_FUNCT_GRP; ins[5:0] = fns[$urandom_range(0, 28)];
            end
            8, 9, 10, 11, 12: ins[31:26] = ops[$urandom_range(0, 7)];
            13: ins[31:26] = ops[$urandom_range(8, 9)];
            14, 15: ins[31:26] = ($urandom_range(0, 1) ? OP_BEQL : OP_BEQ)
                                 + 6'($urandom_range(0, 3));
            16: begin
                ins[31:26] = OP_RT_GRP;
                ins[20:16] = $urandom_range(0, 7) ? rts[$urandom_range(0, 7)]
                                                  : 5'($urandom);
            end
            17: begin
                ins[31:26] = OP_FUNCT_GRP; ins[5:0] = $urandom_range(0, 1) ? FN_JR : FN_JALR;
            end
            default: begin
                ins[31:26] = OP_ORI; ins[25:21] = '0;
            end
        endcase
        return ins;
    endfunction

    task automatic send_word(logic [31:0] ins, logic [31:0] pc);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{instruction: ins, fetch_address: pc};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent++;
    endtask

    task automatic stop_sending();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        stop_sending();
        while (sb.pending.size() != 0 && !timed_out) @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        logic [31:0] pc;
        for (int k = 0; k < n; k++) begin
            pc = $urandom_range(0, 7) ? {22'd0, 8'($urandom_range(0, 255)), 2'b00}
                                      : 32'($urandom);
            send_word(random_word(), pc);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) sb.note_input(i_data);
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_data);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall     <= 1'b0;
            hold_cycles <= 0;
            hold_done   <= 1'b0;
        end else if (hold_armed && !hold_done) begin
            hold_done   <= 1'b1;
            hold_cycles <= 60;
            i_stall     <= 1'b1;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall     <= 1'b1;
        end else begin
            i_stall <= $urandom_range(0, 99) < recv_idle_pct;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 2000 && !timed_out) begin
            timed_out = 1;
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("** mips3_integer_execute_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [31:0] dir [$];
        sb = new();
        sb.clear();
        i_rst_n = 0; i_valid = 0; i_data = '0;
        send_idle_pct = 0; recv_idle_pct = 0; sent = 0; timed_out = 0; hold_armed = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes and special cases
        dir = '{
            {OP_LUI, 5'd0, 5'd1, 16'h8000},          // r1 = negative
            {OP_ORI, 5'd0, 5'd2, 16'hffff},
            {OP_DADD_IMM, 5'd1, 5'd3, 16'hffff},
            {OP_FUNCT_GRP, 5'd1, 5'd2, 5'd4, 5'd31, FN_DSRA32},
            {OP_FUNCT_GRP, 5'd2, 5'd1, 5'd5, 5'd0, FN_DSLLV},
            {OP_FUNCT_GRP, 5'd1, 5'd0, 5'd0, 5'd0, FN_MTHI},
            {OP_FUNCT_GRP, 5'd0, 5'd0, 5'd6, 5'd0, FN_MFHI},
            {OP_ORI, 5'd2, 5'd0, 16'h1234},          // write to r0 discarded
            {OP_BEQ, 5'd0, 5'd0, 16'h7fff},          // taken
            {OP_ADD_IMM, 5'd2, 5'd7, 16'h0001},
            {OP_BEQL, 5'd1, 5'd0, 16'h8000},         // likely not taken, annul
            {OP_ORI, 5'd0, 5'd8, 16'h5555},
            {OP_RT_GRP, 5'd1, RT_BLTZ_LNK_LKLY, 16'h0010},
            {OP_BNE, 5'd0, 5'd0, 16'h0004},          // branch in slot
            {OP_UNUSED, 26'h3ffffff},                // unsupported in slot
            {OP_FUNCT_GRP, 5'd2, 5'd1, 5'd9, 5'd0, FN_SLT},
            {OP_JAL, 26'h3ffffff},
            {OP_FUNCT_GRP, 5'd31, 5'd0, 5'd10, 5'd0, FN_JALR},
            {OP_FUNCT_GRP, 5'd0, 5'd0, 5'd0, 5'd0, FN_SLL},
            {OP_FUNCT_GRP, 5'd1, 5'd2, 5'd11, 5'd0, FN_SLTU},
            {OP_FUNCT_GRP, 5'd0, 5'd0, 5'd0, 5'd0, FN_UNUSED}
        };
        foreach (dir[k]) send_word(dir[k], k == 16 ? 32'hffff_fffc : 32'(k * 4));
        drain();

        send_idle_pct = 26; recv_idle_pct = 76;
        random_phase(450);
        send_idle_pct = 76; recv_idle_pct = 26;
        random_phase(450);
        drain();
        send_idle_pct = 0; recv_idle_pct = 0;
        hold_armed = 1;
        random_phase(480);
        drain();
        repeat (8) @(posedge i_clk);

        $display("covered %0d instructions, %0d results checked, %0d mismatches",
                 sent, sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("** mips3_integer_execute_unit: PASSED **");
        else
            $display("** mips3_integer_execute_unit: FAILED **");
        $finish;
    end
endmodule
